[design/chord_latch_arpeggiator_core_assert.svh]
// ----------------------------------------------------------------------------
// Chord latch arpeggiator assertion macros
// Shared property wrappers for the checker, clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef CHORD_LATCH_ARPEGGIATOR_CORE_ASSERT_SVH
`define CHORD_LATCH_ARPEGGIATOR_CORE_ASSERT_SVH

// Property checked only while out of reset.
`define CLA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked at every edge, reset included.
`define CLA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[design/cla_pkg.sv]
// ----------------------------------------------------------------------------
// Chord latch arpeggiator package
// Default sizes and fixed output counts shared by the core and its checker.
// ----------------------------------------------------------------------------
package cla_pkg;

    localparam int SLOT_COUNT_DEF  = 4;
    localparam int PITCH_WIDTH_DEF = 24;
    // The result always carries four note fields.
    localparam int NOTE_OUTS       = 4;

endpackage

[design/chord_latch_arpeggiator_core.sv]
// ----------------------------------------------------------------------------
// Chord latch arpeggiator core
// Chord memory with rising-edge latch, clear and advance controls and a
// stepping arpeggio pointer.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while no result is stalled and
// returns one result per item. An accepted item lands in an input register;
// when the result register is free, the edge detection, slot update and
// arpeggio search run in one combinational pass into the result register,
// which then presents the result on m_valid. The input register lets one
// further item be taken while a result waits on m_ready, and a full pipeline
// moves one item per cycle while m_ready stays high.

module chord_latch_arpeggiator_core
    import cla_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int PITCH_WIDTH = PITCH_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_latch_high,
    input  logic                          s_clear_high,
    input  logic                          s_advance_high,
    input  logic signed [PITCH_WIDTH-1:0] s_pitch,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_gate,
    output logic signed [PITCH_WIDTH-1:0] m_note_zero,
    output logic signed [PITCH_WIDTH-1:0] m_note_one,
    output logic signed [PITCH_WIDTH-1:0] m_note_two,
    output logic signed [PITCH_WIDTH-1:0] m_note_three,
    output logic signed [PITCH_WIDTH-1:0] m_arp_note
);

    localparam int PTR_W = $clog2(SLOT_COUNT);

    // Input stage.
    logic                   in_valid_reg;
    logic                   in_latch_reg;
    logic                   in_clear_reg;
    logic                   in_advance_reg;
    logic [PITCH_WIDTH-1:0] in_pitch_reg;

    // Chord state.
    logic                   latch_prev_reg, clear_prev_reg, advance_prev_reg;
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       arp_ptr_reg, arp_ptr_next;
    logic [PITCH_WIDTH-1:0] slot_pitch_reg [SLOT_COUNT];
    logic [PITCH_WIDTH-1:0] slot_pitch_next [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]  slot_valid_reg, slot_valid_next;

    // Result stage.
    logic                   out_valid_reg;
    logic                   gate_reg, gate_next;
    logic [PITCH_WIDTH-1:0] note_reg [NOTE_OUTS];
    logic [PITCH_WIDTH-1:0] note_next [NOTE_OUTS];
    logic [PITCH_WIDTH-1:0] arp_note_reg, arp_note_next;

    logic out_load;
    logic in_take;
    logic clear_edge, latch_edge, advance_edge;
    logic [PTR_W-1:0] step_ptr;
    logic [PTR_W:0]   cand_sum;

    assign out_load = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_load;
    assign in_take  = s_valid && s_ready;

    assign clear_edge   = in_clear_reg && !clear_prev_reg;
    assign latch_edge   = in_latch_reg && !latch_prev_reg;
    assign advance_edge = in_advance_reg && !advance_prev_reg;

    // Clear first, then latch; the arpeggio search sees the result of both.
    always_comb begin
        slot_valid_next = slot_valid_reg;
        wr_ptr_next     = wr_ptr_reg;
        arp_ptr_next    = arp_ptr_reg;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            slot_pitch_next[k] = slot_pitch_reg[k];
        end
        if (clear_edge) begin
            slot_valid_next = '0;
            wr_ptr_next     = '0;
            arp_ptr_next    = '0;
            for (int k = 0; k < SLOT_COUNT; k++) begin
                slot_pitch_next[k] = '0;
            end
        end
        if (latch_edge) begin
            slot_pitch_next[wr_ptr_next] = in_pitch_reg;
            slot_valid_next[wr_ptr_next] = 1'b1;
            if (wr_ptr_next == PTR_W'(SLOT_COUNT - 1)) begin
                wr_ptr_next = '0;
            end else begin
                wr_ptr_next = wr_ptr_next + PTR_W'(1);
            end
        end
    end

    // Next active slot after the pointer, wrapping; the lowest active slot
    // when the pointer sits on an empty one. The nearest candidate wins.
    always_comb begin
        step_ptr = arp_ptr_next;
        cand_sum = '0;
        if (slot_valid_next[arp_ptr_next]) begin
            for (int k = SLOT_COUNT; k >= 1; k--) begin
                cand_sum = {1'b0, arp_ptr_next} + (PTR_W + 1)'(k);
                if (cand_sum >= (PTR_W + 1)'(SLOT_COUNT)) begin
                    cand_sum = cand_sum - (PTR_W + 1)'(SLOT_COUNT);
                end
                if (slot_valid_next[cand_sum[PTR_W-1:0]]) begin
                    step_ptr = cand_sum[PTR_W-1:0];
                end
            end
        end else begin
            for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
                if (slot_valid_next[k]) begin
                    step_ptr = PTR_W'(k);
                end
            end
        end
    end

    always_comb begin
        logic [PTR_W-1:0] arp_sel;
        arp_sel   = advance_edge ? step_ptr : arp_ptr_next;
        gate_next = |slot_valid_next;
        for (int k = 0; k < NOTE_OUTS; k++) begin
            if (k < SLOT_COUNT) begin
                note_next[k] = slot_pitch_next[k];
            end else begin
                note_next[k] = '0;
            end
        end
        arp_note_next = gate_next ? slot_pitch_next[arp_sel] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_latch_reg   <= s_latch_high;
            in_clear_reg   <= s_clear_high;
            in_advance_reg <= s_advance_high;
            in_pitch_reg   <= s_pitch;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_prev_reg   <= 1'b0;
            clear_prev_reg   <= 1'b0;
            advance_prev_reg <= 1'b0;
            wr_ptr_reg       <= '0;
            arp_ptr_reg      <= '0;
            slot_valid_reg   <= '0;
            for (int k = 0; k < SLOT_COUNT; k++) begin
                slot_pitch_reg[k] <= '0;
            end
        end else if (in_valid_reg && out_load) begin
            latch_prev_reg   <= in_latch_reg;
            clear_prev_reg   <= in_clear_reg;
            advance_prev_reg <= in_advance_reg;
            wr_ptr_reg       <= wr_ptr_next;
            arp_ptr_reg      <= advance_edge ? step_ptr : arp_ptr_next;
            slot_valid_reg   <= slot_valid_next;
            for (int k = 0; k < SLOT_COUNT; k++) begin
                slot_pitch_reg[k] <= slot_pitch_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && out_load) begin
            gate_reg     <= gate_next;
            arp_note_reg <= arp_note_next;
            for (int k = 0; k < NOTE_OUTS; k++) begin
                note_reg[k] <= note_next[k];
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_gate       = gate_reg;
    assign m_note_zero  = note_reg[0];
    assign m_note_one   = note_reg[1];
    assign m_note_two   = note_reg[2];
    assign m_note_three = note_reg[3];
    assign m_arp_note   = arp_note_reg;

endmodule

[design/cla_checker.sv]
// ----------------------------------------------------------------------------
// Chord latch arpeggiator checker
// Port-level properties of the core, attached to it by a bind statement.
// ----------------------------------------------------------------------------
`include "chord_latch_arpeggiator_core_assert.svh"

module cla_checker
    import cla_pkg::*;
#(
    parameter int PITCH_WIDTH = PITCH_WIDTH_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_gate,
    input logic signed [PITCH_WIDTH-1:0] m_note_zero,
    input logic signed [PITCH_WIDTH-1:0] m_note_one,
    input logic signed [PITCH_WIDTH-1:0] m_note_two,
    input logic signed [PITCH_WIDTH-1:0] m_note_three,
    input logic signed [PITCH_WIDTH-1:0] m_arp_note
);

    // A stalled result item keeps its gate, arpeggio note and first stored note.
    `CLA_ASSERT(a_result_holds,
        (m_valid && !m_ready) |=> (m_valid && $stable(m_gate) && $stable(m_arp_note)
            && $stable(m_note_zero)),
        "stalled result item changed")

    // With no active slot the arpeggio output is silent.
    `CLA_ASSERT(a_arp_zero_when_closed,
        (m_valid && !m_gate) |-> (m_arp_note == '0),
        "arp note nonzero with gate low")

    // Slots only lose their active mark through a clear, which also zeroes them.
    `CLA_ASSERT(a_notes_zero_when_closed,
        (m_valid && !m_gate) |-> (m_note_zero == '0 && m_note_one == '0
            && m_note_two == '0 && m_note_three == '0),
        "stored note nonzero with gate low")

    // The input side is never blocked while the result side is free.
    `CLA_ASSERT(a_ready_when_drained,
        (!m_valid) |-> s_ready,
        "input stalled with empty result register")

endmodule

bind chord_latch_arpeggiator_core cla_checker #(.PITCH_WIDTH(PITCH_WIDTH)) u_cla_checker (.*);

[tb/tb_chord_latch_arpeggiator_core.sv]
// ----------------------------------------------------------------------------
// Chord latch arpeggiator core testbench
// Drives control levels and pitches through the valid/ready input channel,
// predicts the chord slots, gate and arpeggio note for every accepted item,
// and checks each result in order with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_chord_latch_arpeggiator_core;
    import cla_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SLOTS        = SLOT_COUNT_DEF;
    localparam int          PW           = PITCH_WIDTH_DEF;
    localparam int unsigned RANDOM_ITEMS = 1450;
    localparam int unsigned CALM_TAIL    = 200;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    typedef logic [PW-1:0] pitch_t;

    typedef struct packed {
        logic   gate;
        pitch_t note_zero;
        pitch_t note_one;
        pitch_t note_two;
        pitch_t note_three;
        pitch_t arp_note;
    } chord_result_t;

    // Keeps its own copy of the chord memory and the queue of results that
    // the block still owes.
    class chord_scoreboard;
        bit            latch_q;
        bit            clear_q;
        bit            advance_q;
        int unsigned   wr_ptr;
        int unsigned   arp_ptr;
        pitch_t        slot_pitch[SLOTS];
        bit            slot_on[SLOTS];
        chord_result_t owed[$];
        int unsigned   mismatches;
        int unsigned   results_seen;

        function new();
            latch_q      = 1'b0;
            clear_q      = 1'b0;
            advance_q    = 1'b0;
            wr_ptr       = 0;
            arp_ptr      = 0;
            mismatches   = 0;
            results_seen = 0;
            foreach (slot_pitch[k]) begin
                slot_pitch[k] = '0;
                slot_on[k]    = 1'b0;
            end
        endfunction

        function bit any_on();
            foreach (slot_on[k]) begin
                if (slot_on[k]) return 1'b1;
            end
            return 1'b0;
        endfunction

        function pitch_t note_at(int k);
            return (k < SLOTS) ? slot_pitch[k] : '0;
        endfunction

        // Next active slot after the current one, or the lowest active slot
        // when the pointer sits on an empty one.
        function void step_arp();
            int cand;
            if (!any_on()) return;
            if (slot_on[arp_ptr]) begin
                for (int k = 1; k <= SLOTS; k++) begin
                    cand = (arp_ptr + k) % SLOTS;
                    if (slot_on[cand]) begin
                        arp_ptr = cand;
                        return;
                    end
                end
            end else begin
                for (int k = 0; k < SLOTS; k++) begin
                    if (slot_on[k]) begin
                        arp_ptr = k;
                        return;
                    end
                end
            end
        endfunction

        function void note_item(bit lat, bit clr, bit adv, pitch_t p);
            chord_result_t want;
            if (clr && !clear_q) begin
                foreach (slot_pitch[k]) begin
                    slot_pitch[k] = '0;
                    slot_on[k]    = 1'b0;
                end
                wr_ptr  = 0;
                arp_ptr = 0;
            end
            clear_q = clr;
            if (lat && !latch_q) begin
                slot_pitch[wr_ptr] = p;
                slot_on[wr_ptr]    = 1'b1;
                wr_ptr             = (wr_ptr + 1) % SLOTS;
            end
            latch_q = lat;
            if (adv && !advance_q) step_arp();
            advance_q = adv;

            want.gate       = any_on();
            want.note_zero  = note_at(0);
            want.note_one   = note_at(1);
            want.note_two   = note_at(2);
            want.note_three = note_at(3);
            want.arp_note   = want.gate ? slot_pitch[arp_ptr] : '0;
            owed.push_back(want);
        endfunction

        function void compare_field(string name, pitch_t want, pitch_t seen);
            if (want !== seen) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result %0d: %s expected %h, got %h",
                             $time, results_seen, name, want, seen);
            end
        endfunction

        function void check_result(chord_result_t seen);
            chord_result_t want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result with no item waiting: %p", $time, seen);
                return;
            end
            want = owed.pop_front();
            compare_field("gate", pitch_t'(want.gate), pitch_t'(seen.gate));
            compare_field("note_zero", want.note_zero, seen.note_zero);
            compare_field("note_one", want.note_one, seen.note_one);
            compare_field("note_two", want.note_two, seen.note_two);
            compare_field("note_three", want.note_three, seen.note_three);
            compare_field("arp_note", want.arp_note, seen.arp_note);
            results_seen++;
        endfunction

        function int unsigned outstanding();
            return owed.size();
        endfunction
    endclass

    logic   aclk = 1'b0;
    logic   aresetn;
    logic   s_valid;
    logic   s_ready;
    logic   s_latch_high;
    logic   s_clear_high;
    logic   s_advance_high;
    pitch_t s_pitch;
    logic   m_valid;
    logic   m_ready;
    logic   m_gate;
    pitch_t m_note_zero;
    pitch_t m_note_one;
    pitch_t m_note_two;
    pitch_t m_note_three;
    pitch_t m_arp_note;

    chord_scoreboard board = new();
    int unsigned     tx_gap_pct  = 0;
    int unsigned     rx_stall_pct = 0;

    always #1 aclk = ~aclk;

    chord_latch_arpeggiator_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_latch_high   (s_latch_high),
        .s_clear_high   (s_clear_high),
        .s_advance_high (s_advance_high),
        .s_pitch        (s_pitch),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_gate         (m_gate),
        .m_note_zero    (m_note_zero),
        .m_note_one     (m_note_one),
        .m_note_two     (m_note_two),
        .m_note_three   (m_note_three),
        .m_arp_note     (m_arp_note)
    );

    function automatic pitch_t random_pitch();
        case ($urandom_range(0, 11))
            0:       return {1'b0, {(PW-1){1'b1}}};
            1:       return {1'b1, {(PW-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return pitch_t'($urandom());
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_item(bit lat, bit clr, bit adv, pitch_t p);
        s_valid        <= 1'b1;
        s_latch_high   <= lat;
        s_clear_high   <= clr;
        s_advance_high <= adv;
        s_pitch        <= p;
        do @(posedge aclk); while (!s_ready);
        board.note_item(lat, clr, adv, p);
    endtask

    task automatic idle_sender(int unsigned cycles);
        s_valid        <= 1'b0;
        s_latch_high   <= 1'($urandom());
        s_clear_high   <= 1'($urandom());
        s_advance_high <= 1'($urandom());
        s_pitch        <= random_pitch();
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic maybe_gap();
        if ($urandom_range(0, 99) < tx_gap_pct) idle_sender($urandom_range(1, 10));
    endtask

    // Result side: check every accepted result, then pick ready for the next edge.
    initial begin
        int unsigned   stall_left;
        chord_result_t seen;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                seen.gate       = m_gate;
                seen.note_zero  = m_note_zero;
                seen.note_one   = m_note_one;
                seen.note_two   = m_note_two;
                seen.note_three = m_note_three;
                seen.arp_note   = m_arp_note;
                board.check_result(seen);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < rx_stall_pct) begin
                stall_left = $urandom_range(1, 10) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int unsigned random_sent;
        int unsigned phrase_left;
        bit          noisy;
        bit          paused;
        bit          lat;
        bit          clr;
        bit          adv;

        random_sent = 0;
        phrase_left = 0;
        noisy       = 1'b0;
        paused      = 1'b0;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_latch_high   <= 1'b0;
        s_clear_high   <= 1'b0;
        s_advance_high <= 1'b0;
        s_pitch        <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening: edges versus held levels, pointer wrap, latch,
        // clear and advance edges in one item and advance with nothing latched.
        rx_stall_pct = 20;
        tx_gap_pct   = 20;
        send_item(1'b0, 1'b0, 1'b0, 24'h000000); maybe_gap();
        send_item(1'b0, 1'b0, 1'b1, 24'h000000); maybe_gap();
        send_item(1'b1, 1'b0, 1'b0, 24'h7fffff); maybe_gap();
        send_item(1'b1, 1'b0, 1'b0, 24'h111111); maybe_gap();
        send_item(1'b0, 1'b0, 1'b0, 24'h000000); maybe_gap();
        send_item(1'b1, 1'b0, 1'b0, 24'h800000); maybe_gap();
        send_item(1'b0, 1'b0, 1'b1, 24'h000000); maybe_gap();
        send_item(1'b1, 1'b0, 1'b1, 24'hffffff); maybe_gap();
        send_item(1'b0, 1'b0, 1'b0, 24'h000000); maybe_gap();
        send_item(1'b1, 1'b0, 1'b1, 24'h000001); maybe_gap();
        send_item(1'b0, 1'b0, 1'b0, 24'h000000); maybe_gap();
        send_item(1'b1, 1'b0, 1'b1, 24'h400000); maybe_gap();
        send_item(1'b0, 1'b0, 1'b0, 24'h000000); maybe_gap();
        send_item(1'b0, 1'b0, 1'b1, 24'h000000); maybe_gap();
        send_item(1'b0, 1'b0, 1'b0, 24'h000000); maybe_gap();
        send_item(1'b0, 1'b0, 1'b1, 24'h000000); maybe_gap();
        send_item(1'b0, 1'b1, 1'b0, 24'h000000); maybe_gap();
        send_item(1'b1, 1'b1, 1'b1, 24'h0abcde); maybe_gap();
        send_item(1'b0, 1'b0, 1'b0, 24'h000000); maybe_gap();
        send_item(1'b1, 1'b1, 1'b1, 24'h555555); maybe_gap();
        send_item(1'b0, 1'b0, 1'b0, 24'h000000); maybe_gap();
        send_item(1'b1, 1'b0, 1'b0, 24'h2aaaaa); maybe_gap();
        send_item(1'b0, 1'b1, 1'b1, 24'h000000); maybe_gap();
        send_item(1'b1, 1'b0, 1'b0, 24'hc00000); maybe_gap();

        // Random phrases: mostly musical use with rare clears so the slots
        // fill and wrap, some plain noise on all three levels.
        while (random_sent < RANDOM_ITEMS) begin
            if (phrase_left == 0) begin
                phrase_left = $urandom_range(10, 60);
                noisy       = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 2))
                    0:       tx_gap_pct = 0;
                    1:       tx_gap_pct = 10;
                    default: tx_gap_pct = 35;
                endcase
                case ($urandom_range(0, 2))
                    0:       rx_stall_pct = 0;
                    1:       rx_stall_pct = 10;
                    default: rx_stall_pct = 35;
                endcase
            end
            if (random_sent >= RANDOM_ITEMS - CALM_TAIL) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
            if (noisy) begin
                lat = 1'($urandom());
                clr = 1'($urandom());
                adv = 1'($urandom());
            end else begin
                lat = 1'($urandom());
                clr = ($urandom_range(0, 39) == 0);
                adv = ($urandom_range(0, 2) == 0);
            end
            send_item(lat, clr, adv, random_pitch());
            random_sent++;
            phrase_left--;

            // Hold the input side once until the block has drained.
            if (!paused && random_sent == RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                s_valid <= 1'b0;
                do @(posedge aclk); while (board.outstanding() != 0);
            end else begin
                maybe_gap();
            end
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (board.outstanding() != 0);
        repeat (10) @(posedge aclk);
        if (board.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
